FILE: hw/rtl/ps2mct_pkg.sv
package ps2mct_pkg;

    localparam int COORD_BITS     = 12;
    localparam int RES_BITS       = 13;
    localparam int OUT_COORD_BITS = 12;
    localparam int BYTE_BITS      = 8;
    localparam int DELTA_BITS     = BYTE_BITS + 1;
    // position + delta always fits in two more bits, signed
    localparam int SUM_BITS       = COORD_BITS + 2;
    localparam int LIM_BITS       = ((RES_BITS > COORD_BITS) ? RES_BITS : COORD_BITS) + 1;
    localparam int CFG_INDEX_BITS = 2;

    localparam logic [CFG_INDEX_BITS-1:0] CFG_X_RES = CFG_INDEX_BITS'(0);
    localparam logic [CFG_INDEX_BITS-1:0] CFG_Y_RES = CFG_INDEX_BITS'(1);

    localparam logic [RES_BITS-1:0] X_RES_RESET = RES_BITS'(1024);
    localparam logic [RES_BITS-1:0] Y_RES_RESET = RES_BITS'(768);

    // header byte bit positions
    localparam int HDR_LEFT   = 0;
    localparam int HDR_RIGHT  = 1;
    localparam int HDR_MIDDLE = 2;
    localparam int HDR_START  = 3;
    localparam int HDR_X_SIGN = 4;
    localparam int HDR_Y_SIGN = 5;
    localparam int HDR_X_OVF  = 6;
    localparam int HDR_Y_OVF  = 7;

    typedef enum logic [1:0] {
        POS_HEAD   = 2'd0,
        POS_X_MOVE = 2'd1,
        POS_Y_MOVE = 2'd2
    } byte_pos_t;

    // largest legal coordinate for a resolution; zero stays zero, saturates at the coord range
    function automatic logic [COORD_BITS-1:0] limit_of(input logic [RES_BITS-1:0] res);
        logic [LIM_BITS-1:0] res_m1;
        logic [LIM_BITS-1:0] cap;
        res_m1 = LIM_BITS'(res) - LIM_BITS'(1);
        cap    = LIM_BITS'({COORD_BITS{1'b1}});
        if (res == '0)
            limit_of = '0;
        else if (res_m1 > cap)
            limit_of = '1;
        else
            limit_of = res_m1[COORD_BITS-1:0];
    endfunction

    function automatic logic [COORD_BITS-1:0] clamp_coord(
        input logic signed [SUM_BITS-1:0] v,
        input logic        [COORD_BITS-1:0] lim
    );
        if (v[SUM_BITS-1])
            clamp_coord = '0;
        else if ($unsigned(v) > SUM_BITS'(lim))
            clamp_coord = lim;
        else
            clamp_coord = v[COORD_BITS-1:0];
    endfunction

endpackage

FILE: hw/rtl/ps2_mouse_packet_cursor_tracker_top.sv
// A result becomes valid in the cycle after the transfer of a packet's third byte.
// Throughput: one byte per cycle; the result register holds a packet until taken,
// and in_ready drops only when a third byte would land on a result not yet taken.
// Reset (rst_n, async, active low): byte position and cursor go to zero, resolutions
// to 1024 x 768, no result pending.
module ps2_mouse_packet_cursor_tracker_top
    import ps2mct_pkg::*;
(
    input  logic                          clk,
    input  logic                          rst_n,

    input  logic                          cfg_we,
    input  logic [CFG_INDEX_BITS-1:0]     cfg_index,
    input  logic [RES_BITS-1:0]           cfg_data,

    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [BYTE_BITS-1:0]          data_byte,

    output logic                          out_valid,
    input  logic                          out_ready,
    output logic                          left_button,
    output logic                          right_button,
    output logic                          middle_button,
    output logic                          x_overflow,
    output logic                          y_overflow,
    output logic signed [DELTA_BITS-1:0]  delta_x,
    output logic signed [DELTA_BITS-1:0]  delta_y,
    output logic [OUT_COORD_BITS-1:0]     cursor_x,
    output logic [OUT_COORD_BITS-1:0]     cursor_y
);

    logic [RES_BITS-1:0]   x_res_reg;
    logic [RES_BITS-1:0]   y_res_reg;

    byte_pos_t             pos_reg, pos_next;
    logic [BYTE_BITS-1:0]  header_reg, header_next;
    logic [BYTE_BITS-1:0]  x_move_reg, x_move_next;
    logic [COORD_BITS-1:0] pos_x_reg, pos_x_next;
    logic [COORD_BITS-1:0] pos_y_reg, pos_y_next;

    logic                  out_valid_reg, out_valid_next;
    logic [BYTE_BITS-1:0]  res_header_reg;
    logic signed [DELTA_BITS-1:0] res_dx_reg;
    logic signed [DELTA_BITS-1:0] res_dy_reg;

    logic                  in_xfer;
    logic                  emit;
    logic signed [DELTA_BITS-1:0] dx;
    logic signed [DELTA_BITS-1:0] dy;
    logic signed [SUM_BITS-1:0]   sum_x;
    logic signed [SUM_BITS-1:0]   sum_y;

    // configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            x_res_reg <= X_RES_RESET;
            y_res_reg <= Y_RES_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_X_RES: x_res_reg <= cfg_data;
                CFG_Y_RES: y_res_reg <= cfg_data;
                default:   ;
            endcase
        end
    end

    // only a third byte produces a result, so only it waits for the output side
    assign in_ready = (pos_reg != POS_Y_MOVE) || !out_valid_reg || out_ready;
    assign in_xfer  = in_valid && in_ready;

    assign dx    = {header_reg[HDR_X_SIGN], x_move_reg};
    assign dy    = {header_reg[HDR_Y_SIGN], data_byte};
    assign sum_x = $signed({2'b00, pos_x_reg}) + SUM_BITS'(dx);
    assign sum_y = $signed({2'b00, pos_y_reg}) - SUM_BITS'(dy);

    always_comb
    begin
        pos_next    = pos_reg;
        header_next = header_reg;
        x_move_next = x_move_reg;
        pos_x_next  = pos_x_reg;
        pos_y_next  = pos_y_reg;
        emit        = 1'b0;
        if (in_xfer)
        begin
            unique case (pos_reg)
                POS_X_MOVE:
                begin
                    x_move_next = data_byte;
                    pos_next    = POS_Y_MOVE;
                end
                POS_Y_MOVE:
                begin
                    pos_x_next = clamp_coord(sum_x, limit_of(x_res_reg));
                    pos_y_next = clamp_coord(sum_y, limit_of(y_res_reg));
                    pos_next   = POS_HEAD;
                    emit       = 1'b1;
                end
                default:
                begin
                    // waiting for a header: drop bytes without the start bit
                    if (data_byte[HDR_START])
                    begin
                        header_next = data_byte;
                        pos_next    = POS_X_MOVE;
                    end
                    else
                        pos_next = POS_HEAD;
                end
            endcase
        end
    end

    assign out_valid_next = emit ? 1'b1 : (out_ready ? 1'b0 : out_valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg       <= POS_HEAD;
            pos_x_reg     <= '0;
            pos_y_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            pos_reg       <= pos_next;
            pos_x_reg     <= pos_x_next;
            pos_y_reg     <= pos_y_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        header_reg <= header_next;
        x_move_reg <= x_move_next;
        if (emit)
        begin
            res_header_reg <= header_reg;
            res_dx_reg     <= dx;
            res_dy_reg     <= dy;
        end
    end

    assign out_valid     = out_valid_reg;
    assign left_button   = res_header_reg[HDR_LEFT];
    assign right_button  = res_header_reg[HDR_RIGHT];
    assign middle_button = res_header_reg[HDR_MIDDLE];
    assign x_overflow    = res_header_reg[HDR_X_OVF];
    assign y_overflow    = res_header_reg[HDR_Y_OVF];
    assign delta_x       = res_dx_reg;
    assign delta_y       = res_dy_reg;
    // cursor registers hold the last packet's position until the next third byte
    assign cursor_x      = OUT_COORD_BITS'(pos_x_reg);
    assign cursor_y      = OUT_COORD_BITS'(pos_y_reg);

endmodule

FILE: hw/rtl/ps2mct_checker.sv
module ps2mct_checker
    import ps2mct_pkg::*;
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [CFG_INDEX_BITS-1:0]     cfg_index,
    input  logic [RES_BITS-1:0]           cfg_data,
    input  logic                          in_valid,
    input  logic                          in_ready,
    input  logic [BYTE_BITS-1:0]          data_byte,
    input  logic                          out_valid,
    input  logic                          out_ready,
    input  logic                          left_button,
    input  logic                          right_button,
    input  logic                          middle_button,
    input  logic                          x_overflow,
    input  logic                          y_overflow,
    input  logic signed [DELTA_BITS-1:0]  delta_x,
    input  logic signed [DELTA_BITS-1:0]  delta_y,
    input  logic [OUT_COORD_BITS-1:0]     cursor_x,
    input  logic [OUT_COORD_BITS-1:0]     cursor_y
);

    logic [RES_BITS-1:0] x_res_reg;
    logic [RES_BITS-1:0] y_res_reg;

    // shadow of the resolution registers as seen on the config port
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            x_res_reg <= X_RES_RESET;
            y_res_reg <= Y_RES_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_X_RES: x_res_reg <= cfg_data;
                CFG_Y_RES: y_res_reg <= cfg_data;
                default:   ;
            endcase
        end
    end

    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_ready |=> in_valid && $stable(data_byte))
        else $error("offered byte changed before transfer");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(cursor_x) && $stable(cursor_y)
            && $stable(delta_x) && $stable(delta_y) && $stable(left_button)
            && $stable(right_button) && $stable(middle_button)
            && $stable(x_overflow) && $stable(y_overflow))
        else $error("pending result changed before transfer");

    a_result_from_byte: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_valid && in_ready))
        else $error("result appeared without a byte transfer");

    a_cursor_x_bound: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (cursor_x == '0) || (RES_BITS'(cursor_x) < x_res_reg))
        else $error("cursor_x outside screen width");

    a_cursor_y_bound: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (cursor_y == '0) || (RES_BITS'(cursor_y) < y_res_reg))
        else $error("cursor_y outside screen height");

endmodule

bind ps2_mouse_packet_cursor_tracker_top ps2mct_checker u_ps2mct_checker (.*);
